@@ hw/rtl/mrpc_pkg.sv @@
// ----------------------------------------------------------------------------
// mrpc_pkg: shared types and constants of the region permission checker
// function codes, register indexes, reset values and the control word
// that travels down the cell chain
// ----------------------------------------------------------------------------
`default_nettype none

package mrpc_pkg;

	localparam int REGION_COUNT_DEF = 8;
	localparam int ADDRESS_BITS_DEF = 32;
	localparam int FIELD_BITS       = 32;

	localparam int S_TDATA_BITS = 184;
	localparam int S_TUSER_BITS = 2;
	localparam int M_TDATA_BITS = 8;
	localparam int CFG_IDX_BITS = 8;
	localparam int CFG_DAT_BITS = 8;

	typedef enum logic [1:0] {
		FUNC_WRITE    = 2'd0,
		FUNC_SUPERSET = 2'd1,
		FUNC_EXACT    = 2'd2,
		FUNC_RDWR     = 2'd3
	} func_t;

	localparam logic [CFG_IDX_BITS-1:0] CFG_READ_MASK  = 8'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WRITE_MASK = 8'd1;

	localparam logic [7:0] READ_MASK_RST  = 8'h01;
	localparam logic [7:0] WRITE_MASK_RST = 8'h02;

	typedef struct packed {
		func_t      func;
		logic [2:0] slot;
		logic [7:0] rights;
		logic [7:0] need;
		logic       priv;
		logic       rhint;
		logic       whint;
		logic       len_zero;
		logic       wlen_zero;
		logic       wrap_r;
		logic       wrap_w;
		logic       hit;
		logic       rhit;
		logic       whit;
	} ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/mrpc_front.sv @@
// ----------------------------------------------------------------------------
// mrpc_front: entry stage of the checker
// reduces addresses to the address width, forms range ends and the
// wrap and zero-length flags, and starts the control word
// ----------------------------------------------------------------------------
`default_nettype none

module mrpc_front #(
	parameter int ADDRESS_BITS = mrpc_pkg::ADDRESS_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              en,
	input  wire                              in_vld,
	input  mrpc_pkg::func_t                  func,
	input  wire  [2:0]                       entry_slot,
	input  wire  [mrpc_pkg::FIELD_BITS-1:0]  entry_base,
	input  wire  [mrpc_pkg::FIELD_BITS-1:0]  entry_size,
	input  wire  [7:0]                       entry_rights,
	input  wire  [mrpc_pkg::FIELD_BITS-1:0]  address,
	input  wire  [mrpc_pkg::FIELD_BITS-1:0]  length,
	input  wire  [mrpc_pkg::FIELD_BITS-1:0]  write_length,
	input  wire  [7:0]                       need,
	input  wire                              privileged,
	input  wire                              text_readable_hint,
	input  wire                              data_writable_hint,
	output logic                             vld_s1,
	output mrpc_pkg::ctl_t                   ctl_s1,
	output logic [ADDRESS_BITS-1:0]          addr_s1,
	output logic [ADDRESS_BITS-1:0]          end_r_s1,
	output logic [ADDRESS_BITS-1:0]          end_w_s1,
	output logic [ADDRESS_BITS-1:0]          ebase_s1,
	output logic [ADDRESS_BITS-1:0]          esize_s1
);

	localparam int EXT_BITS = ADDRESS_BITS + mrpc_pkg::FIELD_BITS;

	logic [EXT_BITS-1:0]     addr_x, len_x, wlen_x, base_x, size_x;
	logic [ADDRESS_BITS-1:0] addr, len, wlen, end_r, end_w;
	mrpc_pkg::ctl_t          ctl;

	// zero extend, then keep the low address bits
	assign addr_x = {{ADDRESS_BITS{1'b0}}, address};
	assign len_x  = {{ADDRESS_BITS{1'b0}}, length};
	assign wlen_x = {{ADDRESS_BITS{1'b0}}, write_length};
	assign base_x = {{ADDRESS_BITS{1'b0}}, entry_base};
	assign size_x = {{ADDRESS_BITS{1'b0}}, entry_size};

	assign addr  = addr_x[ADDRESS_BITS-1:0];
	assign len   = len_x[ADDRESS_BITS-1:0];
	assign wlen  = wlen_x[ADDRESS_BITS-1:0];
	assign end_r = addr + len;
	assign end_w = addr + wlen;

	always_comb begin
		ctl.func      = func;
		ctl.slot      = entry_slot;
		ctl.rights    = entry_rights;
		ctl.need      = need;
		ctl.priv      = privileged;
		ctl.rhint     = text_readable_hint;
		ctl.whint     = data_writable_hint;
		ctl.len_zero  = (len == '0);
		ctl.wlen_zero = (wlen == '0);
		ctl.wrap_r    = (end_r < addr);
		ctl.wrap_w    = (end_w < addr);
		ctl.hit       = 1'b0;
		ctl.rhit      = 1'b0;
		ctl.whit      = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1   <= ctl;
			addr_s1  <= addr;
			end_r_s1 <= end_r;
			end_w_s1 <= end_w;
			ebase_s1 <= base_x[ADDRESS_BITS-1:0];
			esize_s1 <= size_x[ADDRESS_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/mrpc_cell.sv @@
// ----------------------------------------------------------------------------
// mrpc_cell: one region of the protection table
// holds base, end and rights of its slot, takes slot writes as they pass
// and adds its coverage verdict to the control word of each query
// ----------------------------------------------------------------------------
`default_nettype none

module mrpc_cell #(
	parameter int ADDRESS_BITS = mrpc_pkg::ADDRESS_BITS_DEF,
	parameter int CELL_INDEX   = 0
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     en,
	input  wire  [7:0]              read_mask,
	input  wire  [7:0]              write_mask,
	input  wire                     in_vld,
	input  mrpc_pkg::ctl_t          in_ctl,
	input  wire  [ADDRESS_BITS-1:0] in_addr,
	input  wire  [ADDRESS_BITS-1:0] in_end_r,
	input  wire  [ADDRESS_BITS-1:0] in_end_w,
	input  wire  [ADDRESS_BITS-1:0] in_ebase,
	input  wire  [ADDRESS_BITS-1:0] in_esize,
	output logic                    vld_s1,
	output mrpc_pkg::ctl_t          ctl_s1,
	output logic [ADDRESS_BITS-1:0] addr_s1,
	output logic [ADDRESS_BITS-1:0] end_r_s1,
	output logic [ADDRESS_BITS-1:0] end_w_s1,
	output logic [ADDRESS_BITS-1:0] ebase_s1,
	output logic [ADDRESS_BITS-1:0] esize_s1
);

	localparam logic [5:0] IDX = 6'(CELL_INDEX);

	logic [ADDRESS_BITS-1:0] base_q, end_q, wend;
	logic [7:0]              rights_q;
	logic                    nowrap_q;
	logic                    wr, cov_r, cov_w, fit;
	mrpc_pkg::ctl_t          ctl;

	assign wend  = in_ebase + in_esize;
	assign wr    = en && in_vld && (in_ctl.func == mrpc_pkg::FUNC_WRITE)
	               && ({3'b000, in_ctl.slot} == IDX);
	assign cov_r = nowrap_q && (in_addr >= base_q) && (in_end_r <= end_q);
	assign cov_w = nowrap_q && (in_addr >= base_q) && (in_end_w <= end_q);

	always_comb begin
		if (in_ctl.func == mrpc_pkg::FUNC_EXACT) begin
			fit = (rights_q == in_ctl.need);
		end else begin
			fit = ((rights_q & in_ctl.need) == in_ctl.need);
		end
		ctl      = in_ctl;
		ctl.hit  = in_ctl.hit  | (fit && cov_r);
		ctl.rhit = in_ctl.rhit | (((rights_q & read_mask) == read_mask) && cov_r);
		ctl.whit = in_ctl.whit | (((rights_q & write_mask) == write_mask) && cov_w);
	end

	// region contents, cleared at reset to a zero-size region
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			end_q    <= '0;
			nowrap_q <= 1'b1;
			rights_q <= '0;
		end else if (wr) begin
			base_q   <= in_ebase;
			end_q    <= wend;
			nowrap_q <= (wend >= in_ebase);
			rights_q <= in_ctl.rights;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1   <= ctl;
			addr_s1  <= in_addr;
			end_r_s1 <= in_end_r;
			end_w_s1 <= in_end_w;
			ebase_s1 <= in_ebase;
			esize_s1 <= in_esize;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/mpu_range_permission_check.sv @@
// ----------------------------------------------------------------------------
// mpu_range_permission_check: region table and access permission check
// Usage: every transaction on s_axis carries one item; tuser holds the
// function code (slot write, superset check, exact check, read/write
// check) and tdata the operands. Each item yields one result on m_axis,
// bit 0 of tdata being the allowed flag (a slot write answers zero).
// The items walk a row of REGION_COUNT cells, one region per cell, each
// cell a register stage, behind an entry stage that forms the range ends,
// and in front of an output register. One item is accepted per cycle in
// steady flow, slot writes included, since a write reaches its cell before
// any later query does. When m_axis stalls with a result held, the whole
// row holds and s_axis_tready drops until the result is taken.
// The cfg port writes the read and write rights masks; cfg_ready is always
// high, and the masks should only change while no item is in flight.
// Reset clears all regions to zero size, the masks to their defaults
// (read 0x01, write 0x02) and empties the row.
// ----------------------------------------------------------------------------
`default_nettype none

module mpu_range_permission_check #(
	parameter int REGION_COUNT = mrpc_pkg::REGION_COUNT_DEF,
	parameter int ADDRESS_BITS = mrpc_pkg::ADDRESS_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	// entry_slot, entry_base, entry_size, entry_rights, address, length,
	// write_length, need, privileged, text_readable_hint, data_writable_hint
	input  wire  [mrpc_pkg::S_TDATA_BITS-1:0] s_axis_tdata,
	// func
	input  wire  [mrpc_pkg::S_TUSER_BITS-1:0] s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	// allowed
	output logic [mrpc_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [mrpc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire  [mrpc_pkg::CFG_DAT_BITS-1:0] cfg_data
);

	logic                    en;
	logic [7:0]              read_mask_q, write_mask_q;
	logic                    out_vld_q, allowed_q, allowed;
	mrpc_pkg::func_t         func;

	logic                    vld   [REGION_COUNT+1];
	mrpc_pkg::ctl_t          ctl   [REGION_COUNT+1];
	logic [ADDRESS_BITS-1:0] addr  [REGION_COUNT+1];
	logic [ADDRESS_BITS-1:0] end_r [REGION_COUNT+1];
	logic [ADDRESS_BITS-1:0] end_w [REGION_COUNT+1];
	logic [ADDRESS_BITS-1:0] ebase [REGION_COUNT+1];
	logic [ADDRESS_BITS-1:0] esize [REGION_COUNT+1];

	mrpc_pkg::ctl_t          last;

	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;
	assign func          = mrpc_pkg::func_t'(s_axis_tuser);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_mask_q  <= mrpc_pkg::READ_MASK_RST;
			write_mask_q <= mrpc_pkg::WRITE_MASK_RST;
		end else if (cfg_valid) begin
			if (cfg_index == mrpc_pkg::CFG_READ_MASK) begin
				read_mask_q <= cfg_data;
			end else if (cfg_index == mrpc_pkg::CFG_WRITE_MASK) begin
				write_mask_q <= cfg_data;
			end
		end
	end

	mrpc_front #(
		.ADDRESS_BITS(ADDRESS_BITS)
	) u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.en                 (en),
		.in_vld             (s_axis_tvalid),
		.func               (func),
		.entry_slot         (s_axis_tdata[2:0]),
		.entry_base         (s_axis_tdata[34:3]),
		.entry_size         (s_axis_tdata[66:35]),
		.entry_rights       (s_axis_tdata[74:67]),
		.address            (s_axis_tdata[106:75]),
		.length             (s_axis_tdata[138:107]),
		.write_length       (s_axis_tdata[170:139]),
		.need               (s_axis_tdata[178:171]),
		.privileged         (s_axis_tdata[179]),
		.text_readable_hint (s_axis_tdata[180]),
		.data_writable_hint (s_axis_tdata[181]),
		.vld_s1             (vld[0]),
		.ctl_s1             (ctl[0]),
		.addr_s1            (addr[0]),
		.end_r_s1           (end_r[0]),
		.end_w_s1           (end_w[0]),
		.ebase_s1           (ebase[0]),
		.esize_s1           (esize[0])
	);

	for (genvar i = 0; i < REGION_COUNT; i++) begin : g_cell
		mrpc_cell #(
			.ADDRESS_BITS(ADDRESS_BITS),
			.CELL_INDEX  (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.read_mask  (read_mask_q),
			.write_mask (write_mask_q),
			.in_vld     (vld[i]),
			.in_ctl     (ctl[i]),
			.in_addr    (addr[i]),
			.in_end_r   (end_r[i]),
			.in_end_w   (end_w[i]),
			.in_ebase   (ebase[i]),
			.in_esize   (esize[i]),
			.vld_s1     (vld[i+1]),
			.ctl_s1     (ctl[i+1]),
			.addr_s1    (addr[i+1]),
			.end_r_s1   (end_r[i+1]),
			.end_w_s1   (end_w[i+1]),
			.ebase_s1   (ebase[i+1]),
			.esize_s1   (esize[i+1])
		);
	end

	assign last = ctl[REGION_COUNT];

	always_comb begin
		unique case (last.func)
			mrpc_pkg::FUNC_WRITE: begin
				allowed = 1'b0;
			end
			mrpc_pkg::FUNC_SUPERSET: begin
				allowed = last.priv || last.len_zero || (!last.wrap_r && last.hit);
			end
			mrpc_pkg::FUNC_EXACT: begin
				allowed = !last.len_zero && !last.wrap_r && last.hit;
			end
			mrpc_pkg::FUNC_RDWR: begin
				allowed = last.priv
				          || ((last.len_zero || (!last.wrap_r && last.rhit) || last.rhint)
				          && (last.wlen_zero || (!last.wrap_w && last.whit) || last.whint));
			end
			default: begin
				allowed = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld[REGION_COUNT];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			allowed_q <= allowed;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(mrpc_pkg::M_TDATA_BITS-1){1'b0}}, allowed_q};

endmodule

`default_nettype wire
